[rtl/ffba_pkg.sv]
package ffba_pkg;

    // One row of the block table.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        logic [15:0] owner;
    } entry_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RESERVED = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO     = 3'd3,
        ST_NOFIT    = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] REG_POOL_BASE = 2'd0;
    localparam logic [1:0] REG_POOL_SIZE = 2'd1;

    localparam logic [31:0] POOL_SIZE_RESET = 32'd65536;

    typedef enum logic [3:0] {
        S_REBUILD,
        S_IDLE,
        S_SCAN,
        S_FREE_NB,
        S_MERGE,
        S_UP_RD,
        S_UP_WR,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_RM_RD,
        S_RM_WR,
        S_RESULT
    } state_t;

endpackage

[rtl/first_fit_block_allocator.sv]
// First-fit block allocator with coalescing.
// Input channel (in_valid/in_stall): operation, owner_tag, request_size and
// block_address. A transfer happens when in_valid is high and in_stall low.
// Output channel (out_valid/out_stall): one result per request, holding
// granted_address and status; it stays stable while out_stall is high.
// Configuration: cfg_write with cfg_index 0 (pool base) or 1 (pool size)
// rebuilds the table as a single free block over the pool. Other indexes
// are ignored. Writes must be made only while the block is idle; the block
// itself does not enforce this. The table lives in a single-port-read,
// single-port-write memory with a registered read port. A request scans
// the table entry by entry; a split then writes two entries, a free reads
// the right neighbor and writes the merged block, and entries are moved one
// by one when a split opens a gap or a merge closes one.
// One request is handled at a time; in_stall is low only when idle.
// After reset the table is rebuilt before the first transfer.
// A held result in the output register does not block the next request
// from being accepted; the block only waits to load a new result.
module first_fit_block_allocator #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] owner_tag,
    input  logic [31:0] request_size,
    input  logic [31:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] granted_address,
    output logic [2:0]  status,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ffba_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] ONE = CW'(1);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] src_reg, src_next;
    logic [1:0]    rm_n_reg, rm_n_next;
    logic          op_reg, op_next;
    logic [15:0]   owner_reg, owner_next;
    logic [31:0]   req_size_reg, req_size_next;
    logic [31:0]   req_addr_reg, req_addr_next;
    entry_t        cur_reg, cur_next;
    entry_t        prev_reg, prev_next;
    logic [31:0]   sum_reg, sum_next;
    logic          left_reg, left_next;
    logic          right_reg, right_next;
    status_t       res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [31:0]   pool_base_reg, pool_size_reg;
    logic          out_valid_reg;
    logic [31:0]   granted_address_reg;
    status_t       status_reg;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    logic          in_xfer;
    logic          cfg_hit;
    logic          early_err;
    status_t       early_status;
    logic          last;
    logic          alloc_hit;
    logic          free_hit;
    logic          has_gap_work;
    logic [CW-1:0] rm_pos;
    logic          out_free;

    ffba_table #(.IW(IW)) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Shared decode of the current step.
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign cfg_hit  = cfg_write && (cfg_index == REG_POOL_BASE || cfg_index == REG_POOL_SIZE);
    assign last     = (idx_reg + ONE) == count_reg;
    assign alloc_hit = (rd_data.owner == 16'd0) && (rd_data.size >= req_size_reg);
    assign free_hit  = (rd_data.owner == owner_reg) && (rd_data.base == req_addr_reg);
    assign has_gap_work = count_reg > (idx_reg + ONE);
    assign rm_pos   = (left_reg || !right_reg) ? idx_reg : idx_reg + ONE;
    assign out_free = !out_valid_reg || !out_stall;

    // Errors that are known without touching the table.
    always_comb
    begin
        early_err    = 1'b1;
        early_status = ST_OK;
        if (owner_tag == 16'd0)
        begin
            early_status = ST_RESERVED;
        end
        else if (operation == OP_ALLOC && count_reg >= FULL_COUNT)
        begin
            early_status = ST_FULL;
        end
        else if (operation == OP_ALLOC && request_size == 32'd0)
        begin
            early_status = ST_ZERO;
        end
        else
        begin
            early_err = 1'b0;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_REBUILD: state_next = S_IDLE;
            S_IDLE:
            begin
                if (cfg_hit)
                begin
                    state_next = S_REBUILD;
                end
                else if (in_xfer)
                begin
                    state_next = early_err ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (alloc_hit)
                    begin
                        if (rd_data.size == req_size_reg)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = has_gap_work ? S_UP_RD : S_SPLIT_HI;
                        end
                    end
                    else if (last)
                    begin
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    if (free_hit)
                    begin
                        state_next = S_FREE_NB;
                    end
                    else if (last)
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_FREE_NB: state_next = S_MERGE;
            S_MERGE:
            begin
                if (!left_reg && !right_reg)
                begin
                    state_next = S_RESULT;
                end
                else if ((rm_pos + CW'(rm_n_next)) < count_reg)
                begin
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_RM_RD: state_next = S_RM_WR;
            S_RM_WR: state_next = ((src_reg + ONE) < count_reg) ? S_RM_RD : S_RESULT;
            S_UP_RD: state_next = S_UP_WR;
            S_UP_WR: state_next = (src_reg == idx_reg + ONE) ? S_SPLIT_HI : S_UP_RD;
            S_SPLIT_HI: state_next = S_SPLIT_LO;
            S_SPLIT_LO: state_next = S_RESULT;
            S_RESULT: state_next = out_free ? S_IDLE : S_RESULT;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory control and result values.
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        src_next        = src_reg;
        rm_n_next       = right_reg && left_reg ? 2'd2 : 2'd1;
        op_next         = op_reg;
        owner_next      = owner_reg;
        req_size_next   = req_size_reg;
        req_addr_next   = req_addr_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        sum_next        = sum_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IW-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IW-1:0];
        wr_data         = cur_reg;
        case (state_reg)
            S_REBUILD:
            begin
                // The pool becomes one free block.
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{base: pool_base_reg, size: pool_size_reg, owner: 16'd0};
                count_next = ONE;
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next         = operation;
                    owner_next      = owner_tag;
                    req_size_next   = request_size;
                    req_addr_next   = block_address;
                    res_status_next = early_status;
                    res_addr_next   = 32'd0;
                    idx_next        = '0;
                    rd_en           = 1'b1;
                    rd_addr         = '0;
                end
            end
            S_SCAN:
            begin
                // Keep streaming the next entry; it is the right neighbor on a hit.
                rd_en     = 1'b1;
                rd_addr   = IW'(idx_reg + ONE);
                cur_next  = rd_data;
                prev_next = rd_data;
                if (op_reg == OP_ALLOC)
                begin
                    if (alloc_hit)
                    begin
                        prev_next = prev_reg;
                        src_next  = count_reg - ONE;
                        if (rd_data.size == req_size_reg)
                        begin
                            wr_en           = 1'b1;
                            wr_data         = '{base: rd_data.base, size: rd_data.size,
                                                owner: owner_reg};
                            res_status_next = ST_OK;
                            res_addr_next   = rd_data.base;
                        end
                    end
                    else if (last)
                    begin
                        res_status_next = ST_NOFIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + ONE;
                    end
                end
                else
                begin
                    if (free_hit)
                    begin
                        prev_next = prev_reg;
                        left_next = (idx_reg != '0) && (prev_reg.owner == 16'd0);
                    end
                    else if (last)
                    begin
                        res_status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        idx_next = idx_reg + ONE;
                    end
                end
            end
            S_FREE_NB:
            begin
                right_next = !last && (rd_data.owner == 16'd0);
                sum_next   = cur_reg.size + ((!last && rd_data.owner == 16'd0) ?
                                             rd_data.size : 32'd0);
            end
            S_MERGE:
            begin
                wr_en           = 1'b1;
                res_status_next = ST_OK;
                if (left_reg)
                begin
                    wr_addr = IW'(idx_reg - ONE);
                    wr_data = '{base: prev_reg.base, size: prev_reg.size + sum_reg,
                                owner: 16'd0};
                end
                else
                begin
                    wr_data = '{base: cur_reg.base, size: sum_reg, owner: 16'd0};
                end
                src_next = rm_pos + CW'(rm_n_next);
                if (left_reg || right_reg)
                begin
                    if ((rm_pos + CW'(rm_n_next)) >= count_reg)
                    begin
                        count_next = count_reg - CW'(rm_n_next);
                    end
                end
            end
            S_RM_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = src_reg[IW-1:0];
            end
            S_RM_WR:
            begin
                // Close the gap left by merged entries.
                wr_en    = 1'b1;
                wr_addr  = IW'(src_reg - CW'(rm_n_reg));
                wr_data  = rd_data;
                src_next = src_reg + ONE;
                if ((src_reg + ONE) >= count_reg)
                begin
                    count_next = count_reg - CW'(rm_n_reg);
                end
            end
            S_UP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = src_reg[IW-1:0];
            end
            S_UP_WR:
            begin
                // Open a gap above the split entry, working from the top.
                wr_en    = 1'b1;
                wr_addr  = IW'(src_reg + ONE);
                wr_data  = rd_data;
                src_next = src_reg - ONE;
            end
            S_SPLIT_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = IW'(idx_reg + ONE);
                wr_data = '{base: cur_reg.base + req_size_reg,
                            size: cur_reg.size - req_size_reg, owner: 16'd0};
            end
            S_SPLIT_LO:
            begin
                wr_en           = 1'b1;
                wr_data         = '{base: cur_reg.base, size: req_size_reg, owner: owner_reg};
                count_next      = count_reg + ONE;
                res_status_next = ST_OK;
                res_addr_next   = cur_reg.base;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_REBUILD;
            count_reg     <= ONE;
            pool_base_reg <= 32'd0;
            pool_size_reg <= POOL_SIZE_RESET;
            out_valid_reg <= 1'b0;
            rm_n_reg      <= 2'd1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_MERGE)
            begin
                rm_n_reg <= rm_n_next;
            end
            if (cfg_write && cfg_index == REG_POOL_BASE)
            begin
                pool_base_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_POOL_SIZE)
            begin
                pool_size_reg <= cfg_data;
            end
            if (state_reg == S_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        src_reg        <= src_next;
        op_reg         <= op_next;
        owner_reg      <= owner_next;
        req_size_reg   <= req_size_next;
        req_addr_reg   <= req_addr_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        sum_reg        <= sum_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        if (state_reg == S_RESULT && out_free)
        begin
            granted_address_reg <= res_addr_reg;
            status_reg          <= res_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = granted_address_reg;
    assign status          = status_reg;

endmodule

[rtl/ffba_table.sv]
module ffba_table #(
    parameter int IW = 8
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [IW-1:0]         rd_addr,
    output ffba_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_addr,
    input  ffba_pkg::entry_t      wr_data
);
    import ffba_pkg::*;

    entry_t mem [2**IW];
    entry_t rd_data_reg;

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read port with a registered output.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int TBL_DEPTH = 256;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        status_t     st;
    } grant_result_t;

    // Mirror of the block table and queue of results still owed by the block.
    class alloc_scoreboard;
        logic [31:0]   pool_base_r;
        logic [31:0]   pool_size_r;
        logic [31:0]   tbl_base [TBL_DEPTH];
        logic [31:0]   tbl_size [TBL_DEPTH];
        logic [15:0]   tbl_owner [TBL_DEPTH];
        int            tbl_count;
        grant_result_t owed_q [$];
        int            mismatches;

        function new();
            pool_base_r = '0;
            pool_size_r = POOL_SIZE_RESET;
            mismatches = 0;
            rebuild();
        endfunction

        function void rebuild();
            for (int k = 0; k < TBL_DEPTH; k++)
            begin
                tbl_base[k] = '0;
                tbl_size[k] = '0;
                tbl_owner[k] = '0;
            end
            tbl_base[0] = pool_base_r;
            tbl_size[0] = pool_size_r;
            tbl_count = 1;
        endfunction

        // A pool register write discards every allocation.
        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_POOL_BASE)
            begin
                pool_base_r = data;
                rebuild();
            end
            else if (idx == REG_POOL_SIZE)
            begin
                pool_size_r = data;
                rebuild();
            end
        endfunction

        function void close_gap(int pos, int n);
            for (int k = pos; k + n < tbl_count; k++)
            begin
                tbl_base[k] = tbl_base[k + n];
                tbl_size[k] = tbl_size[k + n];
                tbl_owner[k] = tbl_owner[k + n];
            end
            tbl_count -= n;
        endfunction

        function void open_gap(int pos);
            for (int k = tbl_count; k > pos; k--)
            begin
                tbl_base[k] = tbl_base[k - 1];
                tbl_size[k] = tbl_size[k - 1];
                tbl_owner[k] = tbl_owner[k - 1];
            end
            tbl_count += 1;
        endfunction

        // First-fit search; an exact fit is retagged, a larger block is split.
        function grant_result_t grant(logic [15:0] owner, logic [31:0] size);
            grant_result_t r;
            r.addr = '0;
            if (owner == 0)
            begin
                r.st = ST_RESERVED;
                return r;
            end
            if (tbl_count >= TBL_DEPTH)
            begin
                r.st = ST_FULL;
                return r;
            end
            if (size == 0)
            begin
                r.st = ST_ZERO;
                return r;
            end
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_owner[i] != 0 || tbl_size[i] < size)
                    continue;
                if (tbl_size[i] != size)
                begin
                    open_gap(i + 1);
                    tbl_base[i + 1] = tbl_base[i] + size;
                    tbl_size[i + 1] = tbl_size[i] - size;
                    tbl_owner[i + 1] = '0;
                    tbl_size[i] = size;
                end
                tbl_owner[i] = owner;
                r.addr = tbl_base[i];
                r.st = ST_OK;
                return r;
            end
            r.st = ST_NOFIT;
            return r;
        endfunction

        // Free a taken block and merge it with free neighbors.
        function grant_result_t release_block(logic [15:0] owner, logic [31:0] addr);
            grant_result_t r;
            bit            left;
            bit            right;
            r.addr = '0;
            if (owner == 0)
            begin
                r.st = ST_RESERVED;
                return r;
            end
            for (int i = 0; i < tbl_count; i++)
            begin
                if (tbl_owner[i] != owner || tbl_base[i] != addr)
                    continue;
                tbl_owner[i] = '0;
                left = (i > 0) && tbl_owner[i - 1] == 0;
                right = (i + 1 < tbl_count) && tbl_owner[i + 1] == 0;
                if (left && right)
                begin
                    tbl_size[i - 1] += tbl_size[i] + tbl_size[i + 1];
                    close_gap(i, 2);
                end
                else if (left)
                begin
                    tbl_size[i - 1] += tbl_size[i];
                    close_gap(i, 1);
                end
                else if (right)
                begin
                    tbl_size[i] += tbl_size[i + 1];
                    close_gap(i + 1, 1);
                end
                r.st = ST_OK;
                return r;
            end
            r.st = ST_NOTFOUND;
            return r;
        endfunction

        function void note_request(logic op, logic [15:0] owner, logic [31:0] size,
                                   logic [31:0] addr);
            if (op == OP_ALLOC)
                owed_q.push_back(grant(owner, size));
            else
                owed_q.push_back(release_block(owner, addr));
        endfunction

        function void check_result(logic [31:0] addr, logic [2:0] st);
            grant_result_t exp_r;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: addr %08h status %0d", addr, st);
                return;
            end
            exp_r = owed_q.pop_front();
            if (exp_r.addr !== addr || exp_r.st !== status_t'(st))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Result mismatch: expected addr %08h status %0d,",
                              " got addr %08h status %0d"},
                             exp_r.addr, exp_r.st, addr, st);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [15:0] owner_tag;
    logic [31:0] request_size;
    logic [31:0] block_address;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] granted_address;
    logic [2:0]  status;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    alloc_scoreboard sb = new();

    int send_idle_pct;
    int stall_pct;
    bit holdoff_req;
    int holdoff_left;
    int cycle_count;

    first_fit_block_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .owner_tag(owner_tag),
        .request_size(request_size),
        .block_address(block_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .granted_address(granted_address),
        .status(status),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock with a 12 ns period.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Observe transfers on both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(operation, owner_tag, request_size, block_address);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(granted_address, status);
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        if (holdoff_req)
        begin
            holdoff_left = 1500;
            holdoff_req = 1'b0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Offer one request and hold it until the transfer; called at a falling edge.
    task automatic send(input logic op, input logic [15:0] owner, input logic [31:0] size,
                        input logic [31:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        owner_tag <= owner;
        request_size <= size;
        block_address <= addr;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Register write while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // One random request: mostly allocations and frees of live blocks, some noise.
    task automatic random_request(input bit filling);
        int          pick;
        int          start;
        int          idx;
        logic        op;
        logic [15:0] owner;
        logic [31:0] size;
        logic [31:0] addr;
        pick = $urandom_range(0, 99);
        op = OP_ALLOC;
        owner = 16'($urandom_range(1, 8));
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20000) : $urandom_range(1, 512);
        addr = $urandom;
        if (filling)
            size = $urandom_range(1, 8);
        else if (pick < 88 && pick >= 50)
        begin
            op = OP_FREE;
            start = $urandom_range(0, sb.tbl_count - 1);
            idx = -1;
            for (int k = 0; k < sb.tbl_count && idx < 0; k++)
                if (sb.tbl_owner[(start + k) % sb.tbl_count] != 0)
                    idx = (start + k) % sb.tbl_count;
            if (idx >= 0)
            begin
                owner = sb.tbl_owner[idx];
                addr = sb.tbl_base[idx];
                if (pick >= 84)
                    addr = addr + 1;
            end
        end
        else if (pick >= 88)
        begin
            op = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
            owner = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
            size = $urandom;
        end
        send(op, owner, size, addr);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_ALLOC;
        owner_tag = '0;
        request_size = '0;
        block_address = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_POOL_BASE;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        holdoff_req = 1'b0;
        holdoff_left = 0;
        cycle_count = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: error codes, exact fit, splits, right-only and two-sided merges.
        send(OP_ALLOC, 16'h0, 32'd16, 32'h0);
        send(OP_ALLOC, 16'h1, 32'h0, 32'h0);
        send(OP_ALLOC, 16'h1, 32'hFFFF_FFFF, 32'h0);
        send(OP_ALLOC, 16'hFFFF, 32'd16, 32'h0);
        send(OP_ALLOC, 16'h1, 32'd32, 32'h0);
        send(OP_FREE, 16'h2, 32'h0, 32'd16);
        send(OP_FREE, 16'h0, 32'h0, 32'd16);
        send(OP_FREE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
        send(OP_ALLOC, 16'h3, 32'd16, 32'h0);
        send(OP_FREE, 16'h1, 32'h0, 32'd16);
        send(OP_FREE, 16'h3, 32'h0, 32'h0);
        send(OP_ALLOC, 16'h4, 32'd16, 32'h0);
        send(OP_ALLOC, 16'h5, 32'd16, 32'h0);
        send(OP_ALLOC, 16'h6, 32'd16, 32'h0);
        send(OP_FREE, 16'h4, 32'h0, 32'd0);
        send(OP_FREE, 16'h6, 32'h0, 32'd32);
        send(OP_FREE, 16'h5, 32'h0, 32'd16);
        send(OP_FREE, 16'h5, 32'h0, 32'hFFFF_FFFF);

        // An unknown register index leaves the pool alone.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send(OP_ALLOC, 16'h7, 32'd65536, 32'h0);

        // Empty pool.
        write_reg(REG_POOL_SIZE, 32'h0);
        send(OP_ALLOC, 16'h1, 32'd1, 32'h0);
        send(OP_ALLOC, 16'h1, 32'd0, 32'h0);

        // Pool at the top of the address space wraps around.
        write_reg(REG_POOL_BASE, 32'hFFFF_FFF0);
        write_reg(REG_POOL_SIZE, 32'hFFFF_FFFF);
        send(OP_ALLOC, 16'h2, 32'd32, 32'h0);
        send(OP_ALLOC, 16'h2, 32'd16, 32'h0);
        write_reg(REG_POOL_BASE, 32'h0);
        send(OP_ALLOC, 16'h8, 32'hFFFF_FFFF, 32'h0);

        // Random traffic with no idling on either side.
        write_reg(REG_POOL_SIZE, POOL_SIZE_RESET);
        repeat (100) random_request(1'b0);

        // Small pool; sender idles often.
        write_reg(REG_POOL_BASE, 32'h8000_0000);
        write_reg(REG_POOL_SIZE, 32'd4096);
        send_idle_pct = 65;
        repeat (100) random_request(1'b0);

        // Fill the table until it reports full; receiver stalls often.
        write_reg(REG_POOL_BASE, 32'h1234_5670);
        write_reg(REG_POOL_SIZE, POOL_SIZE_RESET);
        send_idle_pct = 0;
        stall_pct = 65;
        repeat (280) random_request(1'b1);
        repeat (40) random_request(1'b0);

        // Light idling on both sides, with a long receiver hold-off.
        send_idle_pct = 9;
        stall_pct = 9;
        @(posedge clk);
        holdoff_req = 1'b1;
        @(negedge clk);
        repeat (60) random_request(1'b0);

        drain();
        repeat (600) @(negedge clk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
